FILE: rtl/core/mono_bitmap_color_expand_defines.svh
// Assertion macros shared by the color expansion RTL.
`ifndef MONO_BITMAP_COLOR_EXPAND_DEFINES_SVH
`define MONO_BITMAP_COLOR_EXPAND_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define MBCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbce assertion failed");
// Next-cycle implication.
`define MBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbce assertion failed");
`else
`define MBCE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/mbce_pkg.sv
// Shared types and constants for the color expansion block.
package mbce_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ORIGIN_W   = 13;
    localparam int EXTENT_W   = 14;
    localparam int LP_IN_W    = 14;
    localparam int OFFSET_W   = 28;
    localparam int COLOR_W    = 32;

    localparam int MAX_LINE_PIXELS_DEF = 8192;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR  = 3'd6;

    localparam int                  LINE_PIXELS_RST = 1024;
    localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST    = '0;
    localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST    = '0;
    localparam logic [EXTENT_W-1:0] RECT_WIDTH_RST  = 14'd8;
    localparam logic [EXTENT_W-1:0] RECT_HEIGHT_RST = 14'd16;
    localparam logic [COLOR_W-1:0]  FORE_COLOR_RST  = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0]  BACK_COLOR_RST  = 32'h0000_0000;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [EXTENT_W-1:0] rect_width;
        logic [EXTENT_W-1:0] rect_height;
        logic [COLOR_W-1:0]  fore_color;
        logic [COLOR_W-1:0]  back_color;
    } cfg_t;

endpackage

FILE: rtl/core/mbce_cfg_regs.sv
// Configuration register file with line width saturation.
module mbce_cfg_regs
    import mbce_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF,
    parameter int LP_W            = $clog2(MAX_LINE_PIXELS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [LP_W-1:0]       line_pixels,
    output cfg_t                  cfg
);

    localparam int LP_RST = (LINE_PIXELS_RST > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS
                                                                 : LINE_PIXELS_RST;

    logic [LP_W-1:0]    line_pixels_reg;
    logic [LP_W-1:0]    line_pixels_next;
    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [LP_IN_W-1:0] lp_raw;

    assign lp_raw = cfg_data[LP_IN_W-1:0];

    always_comb
    begin
        line_pixels_next = line_pixels_reg;
        cfg_next         = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_PIXELS:
                begin
                    // saturate wide lines
                    if (32'(lp_raw) > 32'(MAX_LINE_PIXELS))
                        line_pixels_next = LP_W'(MAX_LINE_PIXELS);
                    else
                        line_pixels_next = LP_W'(lp_raw);
                end
                REG_ORIGIN_X:    cfg_next.origin_x    = cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:    cfg_next.origin_y    = cfg_data[ORIGIN_W-1:0];
                REG_RECT_WIDTH:  cfg_next.rect_width  = cfg_data[EXTENT_W-1:0];
                REG_RECT_HEIGHT: cfg_next.rect_height = cfg_data[EXTENT_W-1:0];
                REG_FORE_COLOR:  cfg_next.fore_color  = cfg_data[COLOR_W-1:0];
                REG_BACK_COLOR:  cfg_next.back_color  = cfg_data[COLOR_W-1:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pixels_reg     <= LP_W'(LP_RST);
            cfg_reg.origin_x    <= ORIGIN_X_RST;
            cfg_reg.origin_y    <= ORIGIN_Y_RST;
            cfg_reg.rect_width  <= RECT_WIDTH_RST;
            cfg_reg.rect_height <= RECT_HEIGHT_RST;
            cfg_reg.fore_color  <= FORE_COLOR_RST;
            cfg_reg.back_color  <= BACK_COLOR_RST;
        end
        else
        begin
            line_pixels_reg <= line_pixels_next;
            cfg_reg         <= cfg_next;
        end
    end

    assign line_pixels = line_pixels_reg;
    assign cfg         = cfg_reg;

endmodule

FILE: rtl/core/mono_bitmap_color_expand.sv
// A byte's first pixel shows when it moves to the output register, after any stall.
// Throughput: one pixel per cycle while the output is not stalled; each byte yields
// up to eight pixels from the single pixel stepper, and a byte with none is dropped.
// The next byte is taken in the cycle its last pixel moves to the output register.
// Reset: registers return to their defaults, no drawing is active, output empty.
`include "mono_bitmap_color_expand_defines.svh"
module mono_bitmap_color_expand
    import mbce_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  logic [7:0]            bitmap_byte,
    input  logic                  start_drawing,
    output logic                  pixel_valid,
    input  logic                  pixel_ready,
    output logic [OFFSET_W-1:0]   pixel_offset,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic                  last_of_byte,
    output logic                  last_of_drawing
);

    localparam int LP_W   = $clog2(MAX_LINE_PIXELS + 1);
    localparam int PROD_W = ORIGIN_W + LP_W + 1;

    logic [LP_W-1:0] line_pixels;
    cfg_t            cfg;

    mbce_cfg_regs #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .LP_W            (LP_W)
    ) u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .line_pixels (line_pixels),
        .cfg         (cfg)
    );

    // byte stage and drawing position
    logic                busy_reg,     busy_next;
    logic [7:0]          bits_reg,     bits_next;
    logic [2:0]          idx_reg,      idx_next;
    logic [EXTENT_W-1:0] column_reg,   column_next;
    logic [EXTENT_W-1:0] row_reg,      row_next;
    logic [OFFSET_W-1:0] row_base_reg, row_base_next;
    logic                done_reg,     done_next;

    // output register
    logic                pixel_valid_reg, pixel_valid_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic                last_byte_reg;
    logic                last_draw_reg;

    logic                out_free;
    logic                drop;
    logic                emit;
    logic                accept;
    logic [EXTENT_W:0]   col_inc;
    logic [EXTENT_W:0]   row_inc;
    logic                row_end;
    logic                draw_end;
    logic                pix_last;
    logic [PROD_W-1:0]   base_prod;
    logic [OFFSET_W-1:0] start_base;
    logic [OFFSET_W-1:0] pix_offset;

    assign out_free = !pixel_valid_reg || pixel_ready;
    assign drop     = busy_reg && done_reg;
    assign emit     = busy_reg && !done_reg && out_free;

    assign col_inc  = {1'b0, column_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign row_end  = col_inc >= {1'b0, cfg.rect_width};
    assign draw_end = row_end && (row_inc >= {1'b0, cfg.rect_height});
    assign pix_last = (&idx_reg) || draw_end;

    assign byte_ready = !busy_reg || drop || (emit && pix_last);
    assign accept     = byte_valid && byte_ready;

    assign base_prod  = PROD_W'(cfg.origin_y) * PROD_W'(line_pixels)
                      + PROD_W'(cfg.origin_x);
    assign start_base = OFFSET_W'(base_prod);
    assign pix_offset = row_base_reg + OFFSET_W'(column_reg);

    always_comb
    begin
        busy_next     = busy_reg;
        bits_next     = bits_reg;
        idx_next      = idx_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        done_next     = done_reg;

        if (emit)
        begin
            bits_next = {bits_reg[6:0], 1'b0};
            idx_next  = idx_reg + 3'd1;
            if (row_end)
            begin
                column_next   = '0;
                row_next      = row_inc[EXTENT_W-1:0];
                row_base_next = row_base_reg + OFFSET_W'(line_pixels);
                if (draw_end)
                    done_next = 1'b1;
            end
            else
            begin
                column_next = col_inc[EXTENT_W-1:0];
            end
            if (pix_last)
                busy_next = 1'b0;
        end

        if (drop)
            busy_next = 1'b0;

        if (accept)
        begin
            busy_next = 1'b1;
            bits_next = bitmap_byte;
            idx_next  = '0;
            // restart at the top-left corner
            if (start_drawing)
            begin
                column_next   = '0;
                row_next      = '0;
                row_base_next = start_base;
                done_next     = (cfg.rect_width == '0) || (cfg.rect_height == '0);
            end
        end
    end

    always_comb
    begin
        pixel_valid_next = pixel_valid_reg;
        if (emit)
            pixel_valid_next = 1'b1;
        else if (pixel_ready)
            pixel_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            idx_reg         <= '0;
            column_reg      <= '0;
            row_reg         <= '0;
            row_base_reg    <= '0;
            done_reg        <= 1'b1;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            idx_reg         <= idx_next;
            column_reg      <= column_next;
            row_reg         <= row_next;
            row_base_reg    <= row_base_next;
            done_reg        <= done_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (emit)
        begin
            offset_reg    <= pix_offset;
            color_reg     <= bits_reg[7] ? cfg.fore_color : cfg.back_color;
            last_byte_reg <= pix_last;
            last_draw_reg <= draw_end;
        end
    end

    assign pixel_valid     = pixel_valid_reg;
    assign pixel_offset    = offset_reg;
    assign pixel_color     = color_reg;
    assign last_of_byte    = last_byte_reg;
    assign last_of_drawing = last_draw_reg;

    `MBCE_ASSERT_IMPL(a_draw_end_ends_byte, clk, rst_n, pixel_valid && last_of_drawing, last_of_byte)
    `MBCE_ASSERT_IMPL(a_ready_only_on_last, clk, rst_n, busy_reg && !drop && byte_ready, emit && pix_last)
    `MBCE_ASSERT_NEXT(a_draw_end_sets_done, clk, rst_n, emit && draw_end && !accept, done_reg)
    `MBCE_ASSERT_IMPL(a_valid_from_emit, clk, rst_n, $rose(pixel_valid_reg), $past(emit))

endmodule

FILE: verif/tb_top.sv
// Testbench for mono_bitmap_color_expand: predicts every pixel write and checks each one.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbce_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SECTION_BYTES = 85;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [COLOR_W-1:0]  color;
        logic                end_of_byte;
        logic                end_of_drawing;
    } pixel_t;

    // Tracks the registers and drawing position, and the pixel writes still owed.
    class pixel_ledger;
        logic [LP_IN_W-1:0]  line_pixels;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [EXTENT_W-1:0] rect_width;
        logic [EXTENT_W-1:0] rect_height;
        logic [COLOR_W-1:0]  fore_color;
        logic [COLOR_W-1:0]  back_color;
        logic [EXTENT_W-1:0] column;
        logic [EXTENT_W-1:0] row;
        logic [OFFSET_W-1:0] row_base;
        logic                done;
        pixel_t              owed[$];
        int                  mismatches;
        int                  retired;
        int                  finished;

        function new();
            line_pixels = LP_IN_W'(LINE_PIXELS_RST);
            origin_x    = ORIGIN_X_RST;
            origin_y    = ORIGIN_Y_RST;
            rect_width  = RECT_WIDTH_RST;
            rect_height = RECT_HEIGHT_RST;
            fore_color  = FORE_COLOR_RST;
            back_color  = BACK_COLOR_RST;
            column      = '0;
            row         = '0;
            row_base    = '0;
            done        = 1'b1;
            mismatches  = 0;
            retired     = 0;
            finished    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_LINE_PIXELS:
                    line_pixels = (value[LP_IN_W-1:0] > LP_IN_W'(MAX_LINE_PIXELS_DEF)) ?
                                  LP_IN_W'(MAX_LINE_PIXELS_DEF) : value[LP_IN_W-1:0];
                REG_ORIGIN_X:    origin_x    = value[ORIGIN_W-1:0];
                REG_ORIGIN_Y:    origin_y    = value[ORIGIN_W-1:0];
                REG_RECT_WIDTH:  rect_width  = value[EXTENT_W-1:0];
                REG_RECT_HEIGHT: rect_height = value[EXTENT_W-1:0];
                REG_FORE_COLOR:  fore_color  = value;
                REG_BACK_COLOR:  back_color  = value;
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] pattern, logic restart);
            logic [7:0]          bits;
            logic [40:0]         corner;
            logic [EXTENT_W:0]   col_next;
            logic [EXTENT_W:0]   row_next;
            pixel_t              px;
            int                  count;
            bits  = pattern;
            count = 0;
            if (restart)
            begin
                corner   = origin_y * line_pixels + origin_x;
                column   = '0;
                row      = '0;
                row_base = corner[OFFSET_W-1:0];
                done     = (rect_width == 0) || (rect_height == 0);
            end
            for (int i = 0; i < 8 && !done; i++)
            begin
                px.offset         = row_base + column;
                px.color          = bits[7] ? fore_color : back_color;
                px.end_of_byte    = 1'b0;
                px.end_of_drawing = 1'b0;
                bits     = bits << 1;
                col_next = {1'b0, column} + 1'b1;
                if (col_next >= {1'b0, rect_width})
                begin
                    // wrap to the next frame buffer line
                    column   = '0;
                    row_next = {1'b0, row} + 1'b1;
                    row      = row_next[EXTENT_W-1:0];
                    row_base = row_base + line_pixels;
                    if (row_next >= {1'b0, rect_height})
                    begin
                        done              = 1'b1;
                        px.end_of_drawing = 1'b1;
                    end
                end
                else
                begin
                    column = col_next[EXTENT_W-1:0];
                end
                owed.push_back(px);
                count++;
            end
            if (count > 0)
                owed[owed.size()-1].end_of_byte = 1'b1;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task retire_pixel(pixel_t got);
            pixel_t want;
            if (owed.size() == 0)
            begin
                flag_mismatch($sformatf("pixel at offset %h with none pending", got.offset));
                return;
            end
            want = owed.pop_front();
            retired++;
            if (want.end_of_drawing)
                finished++;
            if (got.offset !== want.offset)
                flag_mismatch($sformatf("pixel_offset %h, want %h", got.offset, want.offset));
            if (got.color !== want.color)
                flag_mismatch($sformatf("pixel_color %h, want %h", got.color, want.color));
            if (got.end_of_byte !== want.end_of_byte)
                flag_mismatch($sformatf("last_of_byte %b, want %b at offset %h",
                                        got.end_of_byte, want.end_of_byte, want.offset));
            if (got.end_of_drawing !== want.end_of_drawing)
                flag_mismatch($sformatf("last_of_drawing %b, want %b at offset %h",
                                        got.end_of_drawing, want.end_of_drawing, want.offset));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  byte_valid = 1'b0;
    logic                  byte_ready;
    logic [7:0]            bitmap_byte = '0;
    logic                  start_drawing = 1'b0;
    logic                  pixel_valid;
    logic                  pixel_ready = 1'b0;
    logic [OFFSET_W-1:0]   pixel_offset;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last_of_byte;
    logic                  last_of_drawing;

    pixel_ledger ledger = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int bytes_sent = 0;
    int reg_writes = 0;
    int cycles = 0;

    mono_bitmap_color_expand DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .bitmap_byte     (bitmap_byte),
        .start_drawing   (start_drawing),
        .pixel_valid     (pixel_valid),
        .pixel_ready     (pixel_ready),
        .pixel_offset    (pixel_offset),
        .pixel_color     (pixel_color),
        .last_of_byte    (last_of_byte),
        .last_of_drawing (last_of_drawing)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[mono_bitmap_color_expand] ERROR");
            $finish;
        end
    end

    // Pixel side: check each accepted write, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
                ledger.retire_pixel('{pixel_offset, pixel_color, last_of_byte, last_of_drawing});
            pixel_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] pattern, input logic restart);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 30)
            gap++;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid    <= 1'b1;
        bitmap_byte   <= pattern;
        start_drawing <= restart;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        ledger.take_byte(pattern, restart);
        bytes_sent++;
    endtask

    // Drop the request and wait until every owed pixel is out and the block is quiet.
    task automatic settle();
        byte_valid <= 1'b0;
        while (ledger.outstanding() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        ledger.write_reg(idx, value);
        reg_writes++;
    endtask

    task automatic close_writes();
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] lp, input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] fg, input logic [31:0] bg);
        write_reg(REG_LINE_PIXELS, lp);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_RECT_WIDTH, w);
        write_reg(REG_RECT_HEIGHT, h);
        write_reg(REG_FORE_COLOR, fg);
        write_reg(REG_BACK_COLOR, bg);
        close_writes();
    endtask

    initial
    begin
        int          roll;
        int          n;
        int          tweak_at;
        int          area;
        int          section_start;
        logic [31:0] lp_v;
        logic [31:0] ox_v;
        logic [31:0] oy_v;
        logic [31:0] w_v;
        logic [31:0] h_v;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 24;
        rx_idle_pct = 69;

        // nothing drawn yet: the byte is dropped
        send_byte(8'hA5, 1'b0);
        settle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        close_writes();

        // reset geometry is 8 wide, so each byte fills one row; hold mid-drawing
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        settle();

        // far corner, oversize line length, then shrink width below the column
        set_config(32'h0000_3FFF, 32'h0000_1FFF, 32'h0000_1FFF, 32'd12, 32'd3,
                   32'hFFFF_FFFF, 32'h0000_0000);
        send_byte(8'hFF, 1'b1);
        settle();
        write_reg(REG_RECT_WIDTH, 32'd5);
        close_writes();
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h7E, 1'b0);
        settle();

        // zero line length stacks every row on one line
        set_config(32'd0, 32'd100, 32'd7, 32'd3, 32'd3, 32'h1234_5678, 32'h9ABC_DEF0);
        send_byte(8'h96, 1'b1);
        send_byte(8'h69, 1'b0);
        settle();

        // empty rectangles
        set_config(32'd640, 32'd4, 32'd4, 32'd0, 32'd4, 32'hAAAA_5555, 32'h5555_AAAA);
        send_byte(8'hF0, 1'b1);
        settle();
        write_reg(REG_RECT_WIDTH, 32'd5);
        write_reg(REG_RECT_HEIGHT, 32'd0);
        close_writes();
        send_byte(8'h0F, 1'b1);
        settle();

        // largest extents, restarted before they could finish
        set_config(32'd8192, 32'd0, 32'd0, 32'd16383, 32'd16383, 32'h0000_0000, 32'hFFFF_FFFF);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hE7, 1'b1);
        send_byte(8'h18, 1'b0);
        settle();

        for (int s = 0; s < 3; s++)
        begin
            case (s)
                0: begin tx_idle_pct = 24; rx_idle_pct = 69; end
                1: begin tx_idle_pct = 69; rx_idle_pct = 24; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            section_start = bytes_sent;
            while (bytes_sent - section_start < SECTION_BYTES)
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                begin
                    // stray bytes with random restarts on the current geometry
                    n = $urandom_range(1, 6);
                    repeat (n) send_byte(8'($urandom), $urandom_range(99) < 30);
                end
                else
                begin
                    settle();
                    roll = $urandom_range(99);
                    if (roll < 8)
                        lp_v = 32'd0;
                    else if (roll < 16)
                        lp_v = $urandom_range(8193, 16383);
                    else if (roll < 24)
                        lp_v = $urandom;
                    else
                        lp_v = $urandom_range(1, 8192);
                    ox_v = ($urandom_range(9) == 0) ? $urandom :
                           (($urandom_range(9) == 0) ? 32'd8191 : $urandom_range(8191));
                    oy_v = ($urandom_range(9) == 0) ? $urandom :
                           (($urandom_range(9) == 0) ? 32'd8191 : $urandom_range(8191));
                    roll = $urandom_range(99);
                    w_v = (roll < 6) ? 32'd0 :
                          (roll < 10) ? $urandom_range(8192, 16383) : $urandom_range(1, 24);
                    roll = $urandom_range(99);
                    h_v = (roll < 6) ? 32'd0 :
                          (roll < 10) ? $urandom_range(8192, 16383) : $urandom_range(1, 6);
                    set_config(lp_v, ox_v, oy_v, w_v, h_v, $urandom, $urandom);

                    area = int'(w_v[EXTENT_W-1:0]) * int'(h_v[EXTENT_W-1:0]);
                    if (area == 0)
                        n = 1;
                    else if ((area + 7) / 8 > 12)
                        n = $urandom_range(2, 6);
                    else
                        n = (area + 7) / 8 + $urandom_range(0, 2);
                    tweak_at = (n > 1 && $urandom_range(99) < 12) ? $urandom_range(1, n - 1) : -1;
                    for (int i = 0; i < n; i++)
                    begin
                        if (i == tweak_at)
                        begin
                            // reshape the rectangle while the drawing is open
                            settle();
                            write_reg($urandom_range(1) ? REG_RECT_WIDTH : REG_RECT_HEIGHT,
                                      $urandom_range(1, 24));
                            close_writes();
                        end
                        send_byte(8'($urandom), i == 0);
                    end
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        $display("run covered %0d bitmap bytes and %0d register writes over three pacing mixes",
                 bytes_sent, reg_writes);
        $display("%0d pixel writes checked, %0d rectangles completed, %0d mismatches",
                 ledger.retired, ledger.finished, ledger.mismatches);
        if (ledger.mismatches == 0)
            $display("[mono_bitmap_color_expand] OK");
        else
            $display("[mono_bitmap_color_expand] ERROR");
        $finish;
    end
endmodule
